// File: rtl/core/rmhf_pkg.sv
// Shared types, constants and helpers for the row mean horizon finder.
`default_nettype none

package rmhf_pkg;

  // Frame geometry limits
  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;

  // Field widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned DimW   = 13;
  localparam int unsigned CntW   = 12;
  localparam int unsigned SumW   = 20;
  localparam int unsigned MeanW  = 8;
  localparam int unsigned ThrW   = 8;

  // Divider: one quotient bit per step
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Packed output word width (row_index, row_mean, horizon_row), padded to bytes
  localparam int unsigned OutBits  = CntW + MeanW + DimW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  // APB
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [DimW-1:0] MaxWidthC  = DimW'(MaxWidth);
  localparam logic [DimW-1:0] MaxHeightC = DimW'(MaxHeight);

  // Register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_EMIT
  } ctrl_state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;     // take the input word
    logic div_start;  // load divider with the finished row sum
    logic div_step;   // one restoring division step
    logic emit;       // load output register, update horizon state
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic row_end;    // current input word closes a row
    logic div_last;   // divider on its final step
    logic out_free;   // output register can take a word this cycle
  } dp_status_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [ThrW-1:0] thresh;
  } cfg_t;

  // Clamp a dimension register to 1..hi
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rmhf_cfg.sv
// APB configuration registers for the row mean horizon finder.
`default_nettype none

module rmhf_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rmhf_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [rmhf_pkg::ApbDataW-1:0]  pwdata,
  output logic      [rmhf_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready,
  output rmhf_pkg::cfg_t                      cfg_o
);
  import rmhf_pkg::*;

  logic [DimW-1:0] width_q;
  logic [DimW-1:0] height_q;
  logic [ThrW-1:0] thresh_q;
  logic            wr_en;
  reg_idx_e        idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(640);
      height_q <= DimW'(480);
      thresh_q <= ThrW'(10);
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH:  width_q  <= pwdata[DimW-1:0];
        REG_HEIGHT: height_q <= pwdata[DimW-1:0];
        REG_THRESH: thresh_q <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = ApbDataW'(width_q);
      REG_HEIGHT: prdata = ApbDataW'(height_q);
      REG_THRESH: prdata = ApbDataW'(thresh_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;
  assign cfg_o.thresh = thresh_q;

endmodule

`default_nettype wire

// File: rtl/core/rmhf_ctrl.sv
// Controller state machine: accumulate, divide, emit.
`default_nettype none

module rmhf_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire rmhf_pkg::dp_status_t status_i,
  output rmhf_pkg::ctrl_cmd_t       cmd_o
);
  import rmhf_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.row_end) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/rmhf_dp.sv
// Datapath: row accumulation, serial divider, horizon tracking, output register.
`default_nettype none

module rmhf_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire rmhf_pkg::cfg_t                    cfg_i,
  input  wire rmhf_pkg::ctrl_cmd_t               cmd_i,
  output rmhf_pkg::dp_status_t                   status_o,
  input  wire logic [rmhf_pkg::PixW-1:0]         pixel_i,
  input  wire logic                              frame_start_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [rmhf_pkg::OutDataW-1:0]     out_data_o,
  output logic                                   out_horizon_o,
  output logic                                   out_done_o
);
  import rmhf_pkg::*;

  // Frame state
  logic [CntW-1:0]  col_q, col_d;
  logic [CntW-1:0]  row_q, row_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [MeanW-1:0] prev_q, prev_d;
  logic             found_q, found_d;
  logic [DimW-1:0]  hidx_q, hidx_d;

  // Divider
  logic [DimW-1:0]    dvsr_q;
  logic [DimW-1:0]    rem_q;
  logic [SumW-1:0]    quo_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [DimW:0]      trial;
  logic               ge;

  // Output register
  logic                valid_q;
  logic [OutDataW-1:0] data_q;
  logic                hz_q;
  logic                done_q;

  logic [DimW-1:0]  width_eff;
  logic [DimW-1:0]  height_eff;
  logic [CntW-1:0]  col_eff;
  logic [SumW-1:0]  sum_base;
  logic [SumW-1:0]  sum_new;
  logic [MeanW-1:0] mean;
  logic             hz;
  logic             done;
  logic [DimW-1:0]  hrow;

  assign width_eff  = clamp_dim(cfg_i.width, MaxWidthC);
  assign height_eff = clamp_dim(cfg_i.height, MaxHeightC);

  // Row end test for the incoming word (frame start counts as column 0)
  assign col_eff  = frame_start_i ? '0 : col_q;
  assign sum_base = frame_start_i ? '0 : sum_q;
  assign sum_new  = sum_base + SumW'(pixel_i);

  assign status_o.row_end  = ({1'b0, col_eff} + DimW'(1)) >= width_eff;
  assign status_o.div_last = dcnt_q == DivCntW'(DivSteps - 1);
  assign status_o.out_free = !valid_q || out_ready_i;

  // Restoring division step
  assign trial = {rem_q, quo_q[SumW-1]};
  assign ge    = trial >= {1'b0, dvsr_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvsr_q <= width_eff;
      rem_q  <= '0;
      quo_q  <= sum_new;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? DimW'(trial - {1'b0, dvsr_q}) : trial[DimW-1:0];
      quo_q  <= {quo_q[SumW-2:0], ge};
      dcnt_q <= dcnt_q + DivCntW'(1);
    end
  end

  // Mean saturates at full scale
  assign mean = (|quo_q[SumW-1:MeanW]) ? '1 : quo_q[MeanW-1:0];

  // Horizon decision for the finished row
  assign hz   = !found_q && (row_q >= CntW'(2)) && (mean > prev_q) &&
                (prev_q <= cfg_i.thresh);
  assign done = ({1'b0, row_q} + DimW'(1)) >= height_eff;
  always_comb begin
    hrow = '0;
    if (done) begin
      if (hz) begin
        hrow = {1'b0, row_q};
      end else if (found_q) begin
        hrow = hidx_q;
      end else begin
        hrow = height_eff;
      end
    end
  end

  // Frame state next values
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    sum_d   = sum_q;
    prev_d  = prev_q;
    found_d = found_q;
    hidx_d  = hidx_q;
    if (cmd_i.accept) begin
      if (frame_start_i) begin
        row_d   = '0;
        prev_d  = '0;
        found_d = 1'b0;
        hidx_d  = '0;
      end
      if (status_o.row_end) begin
        col_d = '0;
        sum_d = '0;
      end else begin
        col_d = col_eff + CntW'(1);
        sum_d = sum_new;
      end
    end else if (cmd_i.emit) begin
      if (done) begin
        row_d   = '0;
        prev_d  = '0;
        found_d = 1'b0;
        hidx_d  = '0;
      end else begin
        row_d  = row_q + CntW'(1);
        prev_d = mean;
        if (hz) begin
          found_d = 1'b1;
          hidx_d  = {1'b0, row_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sum_q   <= '0;
      prev_q  <= '0;
      found_q <= 1'b0;
      hidx_q  <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sum_q   <= sum_d;
      prev_q  <= prev_d;
      found_q <= found_d;
      hidx_q  <= hidx_d;
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      data_q <= OutDataW'({hrow, mean, row_q});
      hz_q   <= hz;
      done_q <= done;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_data_o    = data_q;
  assign out_horizon_o = hz_q;
  assign out_done_o    = done_q;

endmodule

`default_nettype wire

// File: rtl/core/row_mean_horizon_finder_top.sv
// Top level of the row mean horizon finder.
`default_nettype none

// Takes 8-bit grey pixels in raster order and emits one word per completed row: the
// row index, the row's truncated mean, a horizon flag and, on the last row of a frame
// (tlast), the horizon row or the image height if none qualified. Pixels are taken while
// tready is high; the pixel that closes a row starts a bit-serial divider, and the quotient
// is then loaded into the output register once that register is free. Input tready is low
// while the divider runs and while a finished word waits for a free output register. Width
// and height registers are clamped to 1..4096.
module row_mean_horizon_finder_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // pixel stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [rmhf_pkg::PixW-1:0]         s_axis_tdata,  // [7:0] pixel
  input  wire logic                              s_axis_tuser,  // [0] frame_start
  // row result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [11:0] row_index, [19:12] row_mean, [32:20] horizon_row, [39:33] zero
  output logic      [rmhf_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                                   m_axis_tuser,  // [0] is_horizon
  output logic                                   m_axis_tlast,  // frame_done
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rmhf_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [rmhf_pkg::ApbDataW-1:0]     pwdata,
  output logic      [rmhf_pkg::ApbDataW-1:0]     prdata,
  output logic                                   pready
);
  import rmhf_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  rmhf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rmhf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rmhf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .pixel_i       (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_horizon_o (m_axis_tuser),
    .out_done_o    (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: sim/tb_row_mean_horizon_finder_top.sv
// Self-checking testbench for the row mean horizon finder top level.
`timescale 1ns / 100ps

module tb_row_mean_horizon_finder_top;
  import rmhf_pkg::*;

  // One pixel word on the input stream
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_start;
  } pixel_word_t;

  // One row word on the output stream
  typedef struct packed {
    logic [CntW-1:0]  row_index;
    logic [MeanW-1:0] row_mean;
    logic             is_horizon;
    logic             frame_done;
    logic [DimW-1:0]  horizon_row;
  } row_word_t;

  localparam int unsigned RxStallCycles = 400;
  localparam int unsigned SettleCycles  = 30;
  localparam int unsigned PixelTarget   = 1450;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [PixW-1:0]     s_axis_tdata  = '0;  // [7:0] pixel
  logic                s_axis_tuser  = 1'b0;  // [0] frame_start
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [11:0] row_index, [19:12] row_mean, [32:20] horizon_row, [39:33] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;  // [0] is_horizon
  logic                m_axis_tlast;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Stimulus and expectations
  pixel_word_t pixel_q[$];
  row_word_t   row_result_q[$];
  int unsigned pixels_queued  = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_checked  = 0;
  int unsigned tx_idle_pct    = 28;
  int unsigned rx_idle_pct    = 64;
  logic        rx_stall_req   = 1'b0;
  int unsigned rx_stall_left  = 0;

  // Register shadows, reset values
  logic [DimW-1:0] width_reg  = DimW'(640);
  logic [DimW-1:0] height_reg = DimW'(480);
  logic [ThrW-1:0] thresh_reg = ThrW'(10);

  // Frame state of the predictor
  logic [CntW-1:0]  col_cnt    = '0;
  logic [CntW-1:0]  row_cnt    = '0;
  logic [SumW-1:0]  pixel_sum  = '0;
  logic [MeanW-1:0] prev_mean  = '0;
  logic             hz_latched = 1'b0;
  logic [DimW-1:0]  hz_row     = '0;

  row_mean_horizon_finder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Dimension register as the block uses it: zero acts as 1, capped at the maximum
  function automatic int unsigned effective_dim(input logic [DimW-1:0] v,
                                                input int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_frame_state();
    col_cnt    = '0;
    row_cnt    = '0;
    pixel_sum  = '0;
    prev_mean  = '0;
    hz_latched = 1'b0;
    hz_row     = '0;
  endfunction

  // Row accumulation, mean and horizon search for one accepted pixel
  function automatic void predict_row_stats(input pixel_word_t w);
    int unsigned eff_w;
    int unsigned eff_h;
    int unsigned quotient;
    row_word_t   r;
    eff_w = effective_dim(width_reg, MaxWidth);
    eff_h = effective_dim(height_reg, MaxHeight);
    if (w.frame_start) clear_frame_state();
    pixel_sum = pixel_sum + SumW'(w.pixel);
    if (int'(col_cnt) + 1 < int'(eff_w)) begin
      col_cnt = col_cnt + 1'b1;
      return;
    end
    // row closes here
    quotient = int'(pixel_sum) / eff_w;
    r.row_mean   = (quotient > 255) ? 8'd255 : MeanW'(quotient);
    r.row_index  = row_cnt;
    r.is_horizon = 1'b0;
    if (!hz_latched && row_cnt >= 2 && r.row_mean > prev_mean && prev_mean <= thresh_reg) begin
      r.is_horizon = 1'b1;
      hz_latched   = 1'b1;
      hz_row       = DimW'(row_cnt);
    end
    r.frame_done  = (int'(row_cnt) + 1 >= int'(eff_h));
    r.horizon_row = '0;
    if (r.frame_done) r.horizon_row = hz_latched ? hz_row : DimW'(eff_h);
    row_result_q.insert(row_result_q.size(), r);
    prev_mean = r.row_mean;
    col_cnt   = '0;
    pixel_sum = '0;
    if (r.frame_done) begin
      clear_frame_state();
    end else begin
      row_cnt = row_cnt + 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("row word %0d: %s got %0d want %0d", words_checked, what, got, want);
    end
  endtask

  task automatic check_row_word();
    row_word_t want;
    if (row_result_q.size() == 0) begin
      report_mismatch("word with none pending, row_index", m_axis_tdata[CntW-1:0], 0);
      return;
    end
    want = row_result_q.pop_front();
    if (m_axis_tdata[CntW-1:0] != want.row_index)
      report_mismatch("row_index", m_axis_tdata[CntW-1:0], want.row_index);
    if (m_axis_tdata[CntW+MeanW-1:CntW] != want.row_mean)
      report_mismatch("row_mean", m_axis_tdata[CntW+MeanW-1:CntW], want.row_mean);
    if (m_axis_tdata[OutBits-1:CntW+MeanW] != want.horizon_row)
      report_mismatch("horizon_row", m_axis_tdata[OutBits-1:CntW+MeanW], want.horizon_row);
    if (m_axis_tdata[OutDataW-1:OutBits] != '0)
      report_mismatch("padding", m_axis_tdata[OutDataW-1:OutBits], 0);
    if (m_axis_tuser != want.is_horizon)
      report_mismatch("is_horizon", m_axis_tuser, want.is_horizon);
    if (m_axis_tlast != want.frame_done)
      report_mismatch("frame_done", m_axis_tlast, want.frame_done);
    words_checked++;
  endtask

  // Pixel driver: predicts on each accepted word, then offers the next one
  always @(posedge clk_i) begin : pixel_driver
    pixel_word_t next_word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_row_stats({s_axis_tdata, s_axis_tuser});
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_word = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_word.pixel;
          s_axis_tuser  <= next_word.frame_start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk_i) begin : rx_stall_counter
    if (!rst_ni) begin
      rx_stall_left <= 0;
    end else if (rx_stall_req) begin
      rx_stall_left <= RxStallCycles;
    end else if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
    end
  end

  // Row word monitor with random backpressure
  always @(posedge clk_i) begin : row_monitor
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_row_word();
      m_axis_tready <= (rx_stall_left == 0) && !rx_stall_req &&
                       ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_pixel(input int unsigned pix, input bit fs);
    pixel_q.insert(pixel_q.size(), {PixW'(pix), fs});
    pixels_queued++;
  endtask

  // Block quiet: nothing queued, nothing offered, nothing pending, divider settled
  task automatic wait_idle();
    while (pixel_q.size() != 0 || s_axis_tvalid || row_result_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [ApbDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg  = value[DimW-1:0];
      REG_HEIGHT: height_reg = value[DimW-1:0];
      REG_THRESH: thresh_reg = value[ThrW-1:0];
      default: ;
    endcase
  endtask

  // Pixel near a row level, with an occasional outlier
  function automatic int unsigned near_level(input int level);
    int v;
    if ($urandom_range(9) == 0) return $urandom_range(255);
    v = level + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  // Random frame: mostly clean raster frames of dark and lit rows, some noise
  task automatic queue_frame(input bit clean);
    int unsigned eff_w;
    int unsigned rows;
    int unsigned level;
    int unsigned n;
    bit          lead_fs;
    eff_w   = effective_dim(width_reg, MaxWidth);
    rows    = effective_dim(height_reg, MaxHeight);
    if (rows > 10) rows = $urandom_range(1, 10);
    lead_fs = ($urandom_range(3) != 0);
    if (clean) begin
      for (int r = 0; r < rows; r++) begin
        level = ($urandom_range(1) == 0) ? $urandom_range(0, thresh_reg) : $urandom_range(255);
        for (int c = 0; c < eff_w && pixels_queued < PixelTarget; c++)
          push_pixel(near_level(level), lead_fs && r == 0 && c == 0);
      end
    end else begin
      n = $urandom_range(1, eff_w * (rows + 1));
      for (int i = 0; i < n && pixels_queued < PixelTarget; i++)
        push_pixel($urandom_range(255), $urandom_range(19) == 0);
    end
  endtask

  task automatic random_config();
    int unsigned sel;
    logic [ApbDataW-1:0] junk;
    junk = $urandom() & 32'hFFFF_E000;
    sel  = $urandom_range(99);
    if (sel < 5) apb_write(REG_WIDTH, junk);
    else if (sel < 25) apb_write(REG_WIDTH, junk | $urandom_range(7, 48));
    else if (sel < 85) apb_write(REG_WIDTH, junk | $urandom_range(1, 6));
    sel = $urandom_range(99);
    if (sel < 5) apb_write(REG_HEIGHT, 0);
    else if (sel < 9) apb_write(REG_HEIGHT, MaxHeight);
    else if (sel < 80) apb_write(REG_HEIGHT, junk | $urandom_range(1, 8));
    sel = $urandom_range(99);
    if (sel < 40) apb_write(REG_THRESH, $urandom_range(0, 20));
    else if (sel < 70) apb_write(REG_THRESH, $urandom());
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // threshold left at its reset value; horizon on row 3, row 1 too early to count
    apb_write(REG_WIDTH, 1);
    apb_write(REG_HEIGHT, 5);
    push_pixel(0, 1); push_pixel(20, 0); push_pixel(3, 0); push_pixel(9, 0); push_pixel(255, 0);

    // zero width and height act as one: every pixel is a whole frame
    wait_idle();
    apb_write(REG_WIDTH, 0);
    apb_write(REG_HEIGHT, 0);
    push_pixel(255, 0); push_pixel(0, 0);

    // width cut mid-row: row ends at once, mean saturates
    wait_idle();
    apb_write(REG_WIDTH, 8);
    apb_write(REG_HEIGHT, 1);
    push_pixel(255, 1);
    repeat (4) push_pixel(255, 0);
    wait_idle();
    apb_write(REG_WIDTH, 2);
    push_pixel(255, 0);

    // height cut mid-frame: next row closes the frame
    wait_idle();
    apb_write(REG_WIDTH, 1);
    apb_write(REG_HEIGHT, 8);
    push_pixel(40, 1); push_pixel(30, 0); push_pixel(50, 0); push_pixel(60, 0);
    wait_idle();
    apb_write(REG_HEIGHT, 2);
    push_pixel(70, 0);

    // zero threshold
    wait_idle();
    apb_write(REG_THRESH, 0);
    apb_write(REG_HEIGHT, 5);
    push_pixel(7, 1); push_pixel(0, 0); push_pixel(0, 0); push_pixel(1, 0); push_pixel(200, 0);

    // full threshold, all data bits set
    wait_idle();
    apb_write(REG_THRESH, 32'hFFFF_FFFF);
    apb_write(REG_HEIGHT, 3);
    push_pixel(0, 1); push_pixel(254, 0); push_pixel(255, 0);

    // frame start in the middle of a row, tallest frame
    wait_idle();
    apb_write(REG_WIDTH, 2);
    apb_write(REG_HEIGHT, MaxHeight);
    push_pixel(10, 1); push_pixel(99, 1); push_pixel(50, 0);

    // receiver holds off while the sender keeps offering: block fills and stalls
    wait_idle();
    apb_write(REG_HEIGHT, 4);
    apb_write(REG_THRESH, 10);
    for (int i = 0; i < 48; i++) push_pixel($urandom_range(255), i % 8 == 0);
    @(posedge clk_i);
    rx_stall_req <= 1'b1;
    @(posedge clk_i);
    rx_stall_req <= 1'b0;

    // width register bits all set: clamped, a short run stays open; width 2 then closes it
    wait_idle();
    apb_write(REG_WIDTH, 32'hFFFF_FFFF);
    apb_write(REG_HEIGHT, 1);
    push_pixel(255, 1);
    repeat (20) push_pixel(255, 0);
    wait_idle();
    apb_write(REG_WIDTH, 2);
    push_pixel(255, 0);

    // random phases
    while (pixels_queued < PixelTarget) begin
      if (pixels_queued >= 2 * PixelTarget / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (pixels_queued >= PixelTarget / 3) begin
        tx_idle_pct = 64;
        rx_idle_pct = 28;
      end
      wait_idle();
      random_config();
      repeat ($urandom_range(2, 6)) queue_frame($urandom_range(9) != 0);
    end

    while (pixel_q.size() != 0 || s_axis_tvalid || row_result_q.size() != 0)
      @(negedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_row_mean_horizon_finder_top: clean");
    end else begin
      $display("tb_row_mean_horizon_finder_top: errors");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #20_000_000;
    $display("tb_row_mean_horizon_finder_top: errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rmhf_pkg.sv
rtl/core/rmhf_cfg.sv
rtl/core/rmhf_ctrl.sv
rtl/core/rmhf_dp.sv
rtl/core/row_mean_horizon_finder_top.sv
sim/tb_row_mean_horizon_finder_top.sv
